// ----- hdl/bclw_pkg.sv -----
package bclw_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int BLOCK_BITS_DEF = 20;

  localparam int ACT_W  = 2;
  localparam int KIND_W = 2;

  // Input action codes
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SYNC  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WBACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACC   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  // Broadcast command from the controller to every slot cell
  typedef struct packed {
    logic lru_touch;   // target slot becomes most recently used
    logic lru_new;     // target slot was not valid before
    logic dirty_set;   // target slot becomes dirty (newest)
    logic dirty_clr;   // target slot becomes clean
    logic load_tag;    // target slot takes the request block
    logic clr_dirty;   // target slot is freshly allocated
  } bclw_cmd_t;

endpackage

// ----- hdl/bclw_cell.sv -----
module bclw_cell #(
  parameter int SLOTS      = bclw_pkg::SLOTS_DEF,
  parameter int BLOCK_BITS = bclw_pkg::BLOCK_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [BLOCK_BITS-1:0]             key,
  input  logic                              sel,
  input  bclw_pkg::bclw_cmd_t               cmd,
  input  logic [$clog2(SLOTS)-1:0]          tgt_lru,
  input  logic [$clog2(SLOTS+1)-1:0]        tgt_drank,
  input  logic [$clog2(SLOTS)-1:0]          nvalid,
  input  logic [$clog2(SLOTS+1)-1:0]        ndirty,
  // chain: first matching hit / LRU / oldest dirty found upstream
  input  logic                              hit_in,
  input  logic [$clog2(SLOTS)-1:0]          hit_idx_in,
  input  logic                              lru_in,
  input  logic [$clog2(SLOTS)-1:0]          lru_idx_in,
  input  logic                              old_in,
  input  logic [$clog2(SLOTS)-1:0]          old_idx_in,
  output logic                              hit_out,
  output logic [$clog2(SLOTS)-1:0]          hit_idx_out,
  output logic                              lru_out,
  output logic [$clog2(SLOTS)-1:0]          lru_idx_out,
  output logic                              old_out,
  output logic [$clog2(SLOTS)-1:0]          old_idx_out,
  output logic [BLOCK_BITS-1:0]             tag,
  output logic                              valid,
  output logic                              dirty,
  output logic [$clog2(SLOTS)-1:0]          lru_rank,
  output logic [$clog2(SLOTS+1)-1:0]        dirty_rank
);
  import bclw_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int DW = $clog2(SLOTS+1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [BLOCK_BITS-1:0] tag_r;
  logic                  valid_r, dirty_r;
  logic [IW-1:0]         lru_r;
  logic [DW-1:0]         drank_r;

  assign tag        = tag_r;
  assign valid      = valid_r;
  assign dirty      = dirty_r;
  assign lru_rank   = lru_r;
  assign dirty_rank = drank_r;

  // priority chain: lowest index wins
  assign hit_out     = hit_in | (valid_r && tag_r == key);
  assign hit_idx_out = hit_in ? hit_idx_in : MY_IDX;
  assign lru_out     = lru_in | (valid_r && lru_r == '0);
  assign lru_idx_out = lru_in ? lru_idx_in : MY_IDX;
  assign old_out     = old_in | (dirty_r && drank_r == '0);
  assign old_idx_out = old_in ? old_idx_in : MY_IDX;

  // state update from the broadcast command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      if (sel) begin
        if (cmd.load_tag) tag_r <= key;
        if (cmd.lru_touch) begin
          lru_r   <= nvalid;
          valid_r <= 1'b1;
        end
        if (cmd.clr_dirty || cmd.dirty_clr) dirty_r <= 1'b0;
        if (cmd.dirty_set) begin
          dirty_r <= 1'b1;
          drank_r <= ndirty;
        end
      end else begin
        if (cmd.lru_touch && !cmd.lru_new && valid_r && lru_r > tgt_lru)
          lru_r <= lru_r - 1'b1;
        if (cmd.dirty_clr && dirty_r && drank_r > tgt_drank)
          drank_r <= drank_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/block_cache_lru_writeback.sv -----
// Tag and policy controller of an LRU write-back block buffer cache.
// Input: raise start with in_action / in_block_number while busy is
// low; the beat is taken at that edge. Read (0) and write (1) look up the
// block, sync (2) writes back every dirty slot oldest first; code 3 is
// dropped without result and without raising busy.
// Output: each result beat shows for one cycle with out_valid high;
// out_last marks the final beat of an item. Kinds: fetch, write back,
// host access, sync done. There is no back pressure.
// Sequence: a lookup stage, then the result stages. A hit is busy in LOOK
// and ACC, a miss into a free slot or a clean victim in LOOK, FETCH and
// ACC, a dirty victim in LOOK, WB (written back first), FETCH and ACC;
// when a valid slot is evicted for a block beyond the disk extent, FETCH
// gives no beat. A sync is busy in a search and a write back per dirty
// slot, then a last search and done. The next beat can be taken at the
// edge that ends the cycle after the final result. The lookup walks a chain
// of one cell per slot; the slot state is updated in the result cycle.
// Reset: synchronous active-low rst_n empties all slots, clears the disk
// extent and returns the controller to idle.
module block_cache_lru_writeback #(
  parameter int SLOTS      = bclw_pkg::SLOTS_DEF,
  parameter int BLOCK_BITS = bclw_pkg::BLOCK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bclw_pkg::ACT_W-1:0]        in_action,
  input  logic [BLOCK_BITS-1:0]             in_block_number,
  output logic                              out_valid,
  output logic [bclw_pkg::KIND_W-1:0]       out_kind,
  output logic [BLOCK_BITS-1:0]             out_block_id,
  output logic [$clog2(SLOTS)-1:0]          out_slot,
  output logic                              out_last
);
  import bclw_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int DW = $clog2(SLOTS+1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_WB    = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_SYNC  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [ACT_W-1:0]      act_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [IW-1:0]         slot_r, slot_nxt;
  logic [DW-1:0]         free_r, free_nxt;
  logic [BLOCK_BITS-1:0] ext_r, ext_nxt;

  // chain wires
  logic [SLOTS:0]        hit_c, lru_c, old_c;
  logic [IW-1:0]         hit_i [SLOTS+1];
  logic [IW-1:0]         lru_i [SLOTS+1];
  logic [IW-1:0]         old_i [SLOTS+1];
  logic [BLOCK_BITS-1:0] tags  [SLOTS];
  logic [IW-1:0]         lranks[SLOTS];
  logic [DW-1:0]         dranks[SLOTS];
  logic [SLOTS-1:0]      valids, dirtys, sel;

  // registered lookup results and combinational slot counts
  logic          hit_r, old_found_r;
  logic [DW-1:0] nvalid_full, ndirty_full;
  logic [IW-1:0] nvalid_b;

  bclw_cmd_t cmd;

  assign hit_c[0] = 1'b0;
  assign lru_c[0] = 1'b0;
  assign old_c[0] = 1'b0;
  assign hit_i[0] = '0;
  assign lru_i[0] = '0;
  assign old_i[0] = '0;

  // counts of valid / dirty slots
  always_comb begin
    nvalid_full = '0;
    ndirty_full = '0;
    for (int i = 0; i < SLOTS; i++) begin
      nvalid_full = nvalid_full + DW'(valids[i]);
      ndirty_full = ndirty_full + DW'(dirtys[i]);
    end
  end
  // touched slot excluded from its own count
  assign nvalid_b = IW'(nvalid_full - DW'(valids[slot_r]));

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      bclw_cell #(.SLOTS(SLOTS), .BLOCK_BITS(BLOCK_BITS), .IDX(g)) u_cell (
        .clk, .rst_n,
        .key(blk_r), .sel(sel[g]), .cmd(cmd),
        .tgt_lru(lranks[slot_r]), .tgt_drank(dranks[slot_r]),
        .nvalid(nvalid_b), .ndirty(ndirty_full),
        .hit_in(hit_c[g]), .hit_idx_in(hit_i[g]),
        .lru_in(lru_c[g]), .lru_idx_in(lru_i[g]),
        .old_in(old_c[g]), .old_idx_in(old_i[g]),
        .hit_out(hit_c[g+1]), .hit_idx_out(hit_i[g+1]),
        .lru_out(lru_c[g+1]), .lru_idx_out(lru_i[g+1]),
        .old_out(old_c[g+1]), .old_idx_out(old_i[g+1]),
        .tag(tags[g]), .valid(valids[g]), .dirty(dirtys[g]),
        .lru_rank(lranks[g]), .dirty_rank(dranks[g])
      );
      assign sel[g] = (slot_r == IW'(g));
    end
  endgenerate

  // controller
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    free_nxt  = free_r;
    ext_nxt   = ext_r;
    cmd       = '0;
    out_valid = 1'b0;
    out_kind  = KIND_ACC;
    out_block_id = blk_r;
    out_slot  = slot_r;
    out_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_action != ACT_NOP)
          state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        // chain settles on the request registers in this cycle
        if (act_r == ACT_SYNC) begin
          slot_nxt  = old_i[SLOTS];
          state_nxt = ST_SYNC;
        end else if (hit_c[SLOTS]) begin
          slot_nxt  = hit_i[SLOTS];
          state_nxt = ST_ACC;
        end else if (free_r != '0) begin
          free_nxt  = free_r - 1'b1;
          slot_nxt  = IW'(free_r - 1'b1);
          state_nxt = ST_FETCH;
        end else begin
          slot_nxt  = lru_i[SLOTS];
          state_nxt = dirtys[lru_i[SLOTS]] ? ST_WB : ST_FETCH;
        end
      end
      ST_WB: begin
        // victim write back
        out_valid    = 1'b1;
        out_kind     = KIND_WBACK;
        out_block_id = tags[slot_r];
        if (tags[slot_r] > ext_r) ext_nxt = tags[slot_r];
        cmd.dirty_clr = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        // allocate slot; fetch only for a fresh slot or a block in extent
        cmd.lru_touch = 1'b1;
        cmd.lru_new   = !valids[slot_r];
        cmd.load_tag  = 1'b1;
        cmd.clr_dirty = 1'b1;
        if (!valids[slot_r] || blk_r <= ext_r) begin
          out_valid = 1'b1;
          out_kind  = KIND_FETCH;
        end
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        out_valid = 1'b1;
        out_kind  = KIND_ACC;
        out_last  = 1'b1;
        if (hit_r) begin
          cmd.lru_touch = 1'b1;
        end
        if (act_r == ACT_WRITE && (!dirtys[slot_r] || !hit_r))
          cmd.dirty_set = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SYNC: begin
        out_valid = 1'b1;
        if (old_found_r) begin
          out_kind      = KIND_WBACK;
          out_block_id  = tags[slot_r];
          if (tags[slot_r] > ext_r) ext_nxt = tags[slot_r];
          cmd.dirty_clr = 1'b1;
          state_nxt     = ST_LOOK;
        end else begin
          out_kind     = KIND_DONE;
          out_block_id = '0;
          out_slot     = '0;
          out_last     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // registers; sync reuses ST_LOOK as its search stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      free_r  <= DW'(SLOTS);
      ext_r   <= '0;
    end else begin
      free_r  <= free_nxt;
      ext_r   <= ext_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      act_r <= in_action;
      blk_r <= in_block_number;
    end
    slot_r <= slot_nxt;
    // lookup outcome kept for the result stages
    if (state_r == ST_LOOK) begin
      hit_r       <= hit_c[SLOTS];
      old_found_r <= old_c[SLOTS];
    end
  end

endmodule
